@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every edge out of reset
`define RAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication, next cycle
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned WIDE_BITS = 2 * WORD_BITS;

    localparam logic [3:0] OP_NORM = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_NEG  = 4'd5;
    localparam logic [3:0] OP_EQ   = 4'd6;
    localparam logic [3:0] OP_NE   = 4'd7;
    localparam logic [3:0] OP_GT   = 4'd8;
    localparam logic [3:0] OP_LT   = 4'd9;
    localparam logic [3:0] OP_LE   = 4'd10;
    localparam logic [3:0] OP_GE   = 4'd11;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,  // capture request, normalize signs
        CMD_GCD_A   = 4'd2,  // start gcd on A
        CMD_RED_A   = 4'd3,  // start divides of A by gcd
        CMD_GCD_B   = 4'd4,
        CMD_RED_B   = 4'd5,
        CMD_MUL1    = 4'd6,  // first cross products
        CMD_MUL2    = 4'd7,  // second products, combine
        CMD_GCD_R   = 4'd8,
        CMD_RED_R   = 4'd9,
        CMD_FINISH  = 4'd10
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic busy;      // gcd loop, pending transfer or shared divider working
        logic early;     // result already known after load
        logic is_cmp;    // comparison op
        logic is_neg;    // negate or normalize: no combine step
    } sts_t;
endpackage

@@ hw/rtl/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module rau_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rau_pkg::WIDE_BITS-1:0] dividend,
    input  logic [rau_pkg::WIDE_BITS-1:0] divisor,
    output logic                          busy,
    output logic [rau_pkg::WIDE_BITS-1:0] quotient,
    output logic [rau_pkg::WIDE_BITS-1:0] remainder
);
    localparam int unsigned W  = rau_pkg::WIDE_BITS;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

@@ hw/rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, cross products, gcd and reduction with a shared divider.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::ctl_t       ctl,
    output rau_pkg::sts_t       sts,
    input  logic [3:0]          operation,
    input  logic [31:0]         a_num,
    input  logic [31:0]         a_den,
    input  logic [31:0]         b_num,
    input  logic [30:0]         b_den,
    output logic [31:0]         res_num,
    output logic [30:0]         res_den,
    output logic                truth,
    output logic [1:0]          status
);
    localparam int unsigned W = rau_pkg::WIDE_BITS;
    localparam logic [W-1:0] LIM = W'((64'd1 << (rau_pkg::WORD_BITS - 1)) - 64'd1);

    logic [3:0]   op_reg;
    logic         an_neg_reg, bn_neg_reg, rn_neg_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg, rn_reg, rd_reg;
    logic [W-1:0] p1_reg, p2_reg;
    logic [W-1:0] ga_reg, gb_reg;   // gcd working pair
    logic [W-1:0] g_reg;
    logic         early_reg;
    logic [1:0]   early_st_reg;
    logic         gcd_run_reg;
    logic         red_phase_reg;    // 0: numerator divide, 1: denominator
    logic [1:0]   gsel_reg;         // which pair is being reduced: 0 A,1 B,2 R
    logic [3:0]   xfer_reg;         // pending divider result handling

    logic         div_start;
    logic [W-1:0] div_dvd, div_dsr, div_q, div_r;
    logic         div_busy;

    logic         in_an_neg, in_ad_neg;
    logic [31:0]  in_an_mag, in_ad_mag, in_bn_mag;

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_an_neg = a_num[31];
    assign in_ad_neg = a_den[31];
    assign in_an_mag = in_an_neg ? (~a_num + 32'd1) : a_num;
    assign in_ad_mag = in_ad_neg ? (~a_den + 32'd1) : a_den;
    assign in_bn_mag = b_num[31] ? (~b_num + 32'd1) : b_num;

    // signed-magnitude sum of p1 (sign s1) and p2 (sign s2)
    logic         s1, s2, sum_neg;
    logic [W-1:0] sum_mag;
    always_comb
    begin
        s1 = an_neg_reg;
        s2 = bn_neg_reg ^ (op_reg == rau_pkg::OP_SUB) ^
             (op_reg != rau_pkg::OP_ADD && op_reg != rau_pkg::OP_SUB);
        if (s1 == s2)
        begin
            sum_neg = s1;
            sum_mag = p1_reg + p2_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_neg = s1;
            sum_mag = p1_reg - p2_reg;
        end
        else
        begin
            sum_neg = s2;
            sum_mag = p2_reg - p1_reg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    // divider feed
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = ga_reg;
        div_dsr   = gb_reg;
        if (gcd_run_reg && !div_busy && xfer_reg == 4'd0 && gb_reg != '0)
            div_start = 1'b1;
        else if (xfer_reg == 4'd2)
        begin
            div_start = 1'b1;
            div_dvd   = red_phase_reg ? (gsel_reg == 2'd0 ? ad_reg :
                        gsel_reg == 2'd1 ? bd_reg : rd_reg) :
                        (gsel_reg == 2'd0 ? an_reg : gsel_reg == 2'd1 ? bn_reg : rn_reg);
            div_dsr   = g_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcd_run_reg   <= 1'b0;
            xfer_reg      <= 4'd0;
            red_phase_reg <= 1'b0;
            early_reg     <= 1'b0;
        end
        else
        begin
            case (ctl.cmd)
                rau_pkg::CMD_LOAD:
                begin
                    early_reg <= (operation > rau_pkg::OP_GE) || (a_den == '0) ||
                                 (operation != rau_pkg::OP_NORM &&
                                  operation != rau_pkg::OP_NEG && b_den == '0) ||
                                 (operation == rau_pkg::OP_DIV && b_num == '0);
                end
                rau_pkg::CMD_GCD_A, rau_pkg::CMD_GCD_B, rau_pkg::CMD_GCD_R:
                begin
                    gcd_run_reg <= 1'b1;
                    xfer_reg    <= 4'd0;
                end
                rau_pkg::CMD_RED_A, rau_pkg::CMD_RED_B, rau_pkg::CMD_RED_R:
                begin
                    red_phase_reg <= 1'b0;
                    xfer_reg      <= (ga_reg > W'(1)) ? 4'd2 : 4'd0;
                end
                default:
                begin
                end
            endcase
            // gcd loop: a,b <- b, a%b
            if (gcd_run_reg)
            begin
                if (xfer_reg == 4'd0 && gb_reg == '0)
                    gcd_run_reg <= 1'b0;
                else if (div_start)
                    xfer_reg <= 4'd1;
                else if (xfer_reg == 4'd1 && !div_busy)
                    xfer_reg <= 4'd0;
            end
            else if (xfer_reg == 4'd2)
                xfer_reg <= 4'd3;
            else if (xfer_reg == 4'd3 && !div_busy)
            begin
                if (!red_phase_reg)
                begin
                    red_phase_reg <= 1'b1;
                    xfer_reg      <= 4'd2;
                end
                else
                    xfer_reg <= 4'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            rau_pkg::CMD_LOAD:
            begin
                op_reg       <= operation;
                an_neg_reg   <= (in_an_neg ^ in_ad_neg) && (a_num != '0);
                an_reg       <= W'(in_an_mag);
                ad_reg       <= W'(in_ad_mag);
                bn_neg_reg   <= b_num[31];
                bn_reg       <= W'(in_bn_mag);
                bd_reg       <= (b_den == '0) ? W'(1) : W'(b_den);
                early_st_reg <= (operation > rau_pkg::OP_GE) ? rau_pkg::ST_OK :
                                rau_pkg::ST_ZERO_DEN;
            end
            rau_pkg::CMD_GCD_A:
            begin
                ga_reg <= an_reg;
                gb_reg <= ad_reg;
                gsel_reg <= 2'd0;
            end
            rau_pkg::CMD_GCD_B:
            begin
                ga_reg <= bn_reg;
                gb_reg <= bd_reg;
                gsel_reg <= 2'd1;
            end
            rau_pkg::CMD_GCD_R:
            begin
                ga_reg <= rn_reg;
                gb_reg <= rd_reg;
                gsel_reg <= 2'd2;
            end
            rau_pkg::CMD_RED_A, rau_pkg::CMD_RED_B, rau_pkg::CMD_RED_R:
                g_reg <= ga_reg;
            rau_pkg::CMD_MUL1:
            begin
                if (op_reg == rau_pkg::OP_MUL)
                begin
                    p1_reg <= an_reg[31:0] * bn_reg[31:0];
                    p2_reg <= ad_reg[31:0] * bd_reg[31:0];
                end
                else if (op_reg == rau_pkg::OP_DIV)
                begin
                    p1_reg <= an_reg[31:0] * bd_reg[31:0];
                    p2_reg <= ad_reg[31:0] * bn_reg[31:0];
                end
                else
                begin
                    p1_reg <= an_reg[31:0] * bd_reg[31:0];
                    p2_reg <= bn_reg[31:0] * ad_reg[31:0];
                end
            end
            rau_pkg::CMD_MUL2:
            begin
                if (op_reg == rau_pkg::OP_MUL)
                begin
                    rn_neg_reg <= (an_neg_reg ^ bn_neg_reg) && (p1_reg != '0);
                    rn_reg     <= p1_reg;
                    rd_reg     <= p2_reg;
                end
                else if (op_reg == rau_pkg::OP_DIV)
                begin
                    rn_neg_reg <= (an_neg_reg ^ bn_neg_reg) && (p1_reg != '0);
                    rn_reg     <= p1_reg;
                    rd_reg     <= p2_reg;
                end
                else if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                begin
                    rn_neg_reg <= sum_neg;
                    rn_reg     <= sum_mag;
                    rd_reg     <= ad_reg[31:0] * bd_reg[31:0];
                end
                else
                begin
                    rn_neg_reg <= sum_neg;
                    rn_reg     <= sum_mag;
                    rd_reg     <= W'(1);
                end
            end
            rau_pkg::CMD_FINISH:
            begin
                if (op_reg == rau_pkg::OP_NORM || op_reg == rau_pkg::OP_NEG)
                begin
                    rn_neg_reg <= an_neg_reg ^ ((op_reg == rau_pkg::OP_NEG) &&
                                  (an_reg != '0));
                    rn_reg     <= an_reg;
                    rd_reg     <= ad_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (gcd_run_reg && xfer_reg == 4'd1 && !div_busy)
        begin
            ga_reg <= gb_reg;
            gb_reg <= div_r;
        end
        if (!gcd_run_reg && xfer_reg == 4'd3 && !div_busy)
        begin
            case (gsel_reg)
                2'd0:
                    if (red_phase_reg) ad_reg <= div_q; else an_reg <= div_q;
                2'd1:
                    if (red_phase_reg) bd_reg <= div_q; else bn_reg <= div_q;
                default:
                    if (red_phase_reg) rd_reg <= div_q; else rn_reg <= div_q;
            endcase
        end
    end

    assign sts.busy   = gcd_run_reg || (xfer_reg != 4'd0) || div_busy;
    assign sts.early  = early_reg;
    assign sts.is_cmp = (op_reg >= rau_pkg::OP_EQ) && (op_reg <= rau_pkg::OP_GE);
    assign sts.is_neg = (op_reg == rau_pkg::OP_NORM) || (op_reg == rau_pkg::OP_NEG);

    // result forming from the final registers
    logic ovf, c_zero, c_neg;
    assign ovf    = (rn_reg > LIM) || (rd_reg > LIM);
    assign c_zero = (rn_reg == '0);
    assign c_neg  = rn_neg_reg;

    always_comb
    begin
        res_num = '0;
        res_den = 31'd1;
        truth   = 1'b0;
        status  = rau_pkg::ST_OK;
        if (early_reg)
            status = early_st_reg;
        else if (sts.is_cmp)
        begin
            case (op_reg)
                rau_pkg::OP_EQ: truth = c_zero;
                rau_pkg::OP_NE: truth = !c_zero;
                rau_pkg::OP_GT: truth = !c_zero && !c_neg;
                rau_pkg::OP_LT: truth = c_neg;
                rau_pkg::OP_LE: truth = c_zero || c_neg;
                default:        truth = !c_neg;
            endcase
        end
        else if (ovf)
            status = rau_pkg::ST_OVERFLOW;
        else
        begin
            res_num = rn_neg_reg ? (~rn_reg[31:0] + 32'd1) : rn_reg[31:0];
            res_den = rd_reg[30:0];
        end
    end
endmodule

@@ hw/rtl/rau_control.sv @@
// ----------------------------------------------------------------------------
// rau_control
// Sequencer: load, reduce operands, form products, reduce result, deliver.
// ----------------------------------------------------------------------------
module rau_control (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic          out_fire,
    input  rau_pkg::sts_t sts,
    output rau_pkg::ctl_t ctl,
    output logic          idle,
    output logic          done
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_LOAD  = 13'b0000000000010,
        S_GA    = 13'b0000000000100,
        S_RA    = 13'b0000000001000,
        S_GB    = 13'b0000000010000,
        S_RB    = 13'b0000000100000,
        S_M1    = 13'b0000001000000,
        S_M2    = 13'b0000010000000,
        S_GR    = 13'b0000100000000,
        S_RR    = 13'b0001000000000,
        S_FIN   = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_WAIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ctl.cmd    = rau_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    ctl.cmd    = rau_pkg::CMD_LOAD;
                    state_next = S_LOAD;
                end
            S_LOAD:
                state_next = sts.early ? S_DONE : S_GA;
            S_GA:
            begin
                ctl.cmd    = rau_pkg::CMD_GCD_A;
                ret_next   = S_RA;
                state_next = S_WAIT;
            end
            S_RA:
            begin
                ctl.cmd    = rau_pkg::CMD_RED_A;
                ret_next   = sts.is_neg ? S_FIN : S_GB;
                state_next = S_WAIT;
            end
            S_GB:
            begin
                ctl.cmd    = rau_pkg::CMD_GCD_B;
                ret_next   = S_RB;
                state_next = S_WAIT;
            end
            S_RB:
            begin
                ctl.cmd    = rau_pkg::CMD_RED_B;
                ret_next   = S_M1;
                state_next = S_WAIT;
            end
            S_M1:
            begin
                ctl.cmd    = rau_pkg::CMD_MUL1;
                state_next = S_M2;
            end
            S_M2:
            begin
                ctl.cmd    = rau_pkg::CMD_MUL2;
                state_next = sts.is_cmp ? S_DONE : S_GR;
            end
            S_GR:
            begin
                ctl.cmd    = rau_pkg::CMD_GCD_R;
                ret_next   = S_RR;
                state_next = S_WAIT;
            end
            S_RR:
            begin
                ctl.cmd    = rau_pkg::CMD_RED_R;
                ret_next   = S_DONE;
                state_next = S_WAIT;
            end
            S_FIN:
            begin
                ctl.cmd    = rau_pkg::CMD_FINISH;
                state_next = S_DONE;
            end
            S_WAIT:
                if (!sts.busy)
                    state_next = ret_reg;
            S_DONE:
                if (out_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
endmodule

@@ hw/rtl/rational_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational arithmetic on 32-bit fractions with gcd reduction.
// ----------------------------------------------------------------------------
// One request carries an operation and two fractions; one result comes back
// per request. Requests are handled one at a time. The time per item is set by
// the shared restoring divider, which serves every remainder step of the three
// gcd loops (operand A, operand B, result) and the two quotient divides of each
// reduction. The worst case is Fibonacci-like operands, which need the most gcd
// steps. Comparisons skip the result reduction; normalize and negate reduce
// only A. Errors found at load (zero denominator, divide by zero fraction,
// unused code) go from the load state straight to delivery. The result is held
// on the master side until taken.
module rational_arithmetic_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [127:0] s_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64],
                                   // b_den[126:96], zero pad [127]
    input  logic [3:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // res_num[31:0], res_den[62:32], truth[63]
    output logic [1:0]  m_tuser    // status
);
    `include "assert_macros.svh"

    rau_pkg::ctl_t ctl;
    rau_pkg::sts_t sts;
    logic idle, done, in_fire, out_fire;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        truth;

    // accept only when the sequencer is free
    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = done;
    assign out_fire = m_tvalid && m_tready;

    rau_control u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .sts      (sts),
        .ctl      (ctl),
        .idle     (idle),
        .done     (done)
    );

    rau_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .operation (s_tuser),
        .a_num     (s_tdata[31:0]),
        .a_den     (s_tdata[63:32]),
        .b_num     (s_tdata[95:64]),
        .b_den     (s_tdata[126:96]),
        .res_num   (res_num),
        .res_den   (res_den),
        .truth     (truth),
        .status    (m_tuser)
    );

    assign m_tdata = {truth, res_den, res_num};

    // never accept and deliver in the same cycle
    `RAU_ASSERT(a_excl, !(s_tready && m_tvalid), "ready while result pending")
    // a delivered result returns the sequencer to idle
    `RAU_ASSERT_NEXT(a_ret, out_fire, s_tready, "not idle after delivery")
    // an accepted request is not reported in the next cycle
    `RAU_ASSERT_NEXT(a_lat, in_fire, !m_tvalid, "result too early")
endmodule
